// ----- rtl/core/m68k_line_c_execute_unit_macros.svh -----
// Assertion macros shared by the line-C execute unit.
`ifndef M68K_LINE_C_EXECUTE_UNIT_MACROS_SVH
`define M68K_LINE_C_EXECUTE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define M68K_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: consequent did not hold in the same cycle");

// Next-cycle implication, checked on every rising edge outside reset.
`define M68K_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: consequent did not hold in the next cycle");

`else

`define M68K_ASSERT_NOW(label, clk, rstn, ante, cons)
`define M68K_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/m68k_lc_pkg.sv -----
// Package with the instruction classes, field codes and decoder of the line-C execute unit.
package m68k_lc_pkg;

    // Transaction modes.
    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Top nibble of every line-C opcode.
    localparam logic [3:0] LINE_C = 4'hC;

    // Opmode field values.
    localparam logic [2:0] OPM_LONG_TO_DN = 3'd2;
    localparam logic [2:0] OPM_MULU      = 3'd3;
    localparam logic [2:0] OPM_EXG_SAME  = 3'd5;
    localparam logic [2:0] OPM_EXG_MIXED = 3'd6;
    localparam logic [2:0] OPM_MULS      = 3'd7;

    // Effective-address mode and register values.
    localparam logic [2:0] EA_DREG     = 3'd0;
    localparam logic [2:0] EA_AREG     = 3'd1;
    localparam logic [2:0] EA_SPECIAL  = 3'd7;
    localparam logic [2:0] EA_LAST_SRC = 3'd4;
    localparam logic [2:0] EA_LAST_MEM = 3'd1;

    // Operand sizes.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    // Instruction classes after decode.
    localparam logic [3:0] CLS_UNH     = 4'd0;
    localparam logic [3:0] CLS_AND_DN  = 4'd1;
    localparam logic [3:0] CLS_MUL     = 4'd2;
    localparam logic [3:0] CLS_AND_MEM = 4'd3;
    localparam logic [3:0] CLS_EXG_DD  = 4'd4;
    localparam logic [3:0] CLS_EXG_AA  = 4'd5;
    localparam logic [3:0] CLS_EXG_DA  = 4'd6;
    localparam logic [3:0] CLS_LOAD    = 4'd7;
    localparam logic [3:0] CLS_READ    = 4'd8;

    // Classifies one transaction into the operation that the execute stage performs.
    function automatic logic [3:0] decode_op(input logic [1:0] mode, input logic [15:0] opcode);
        logic [2:0] opm;
        logic [2:0] em;
        logic [2:0] er;
        logic       src_ok;
        logic       mem_ok;
        logic [3:0] cls;
        opm    = opcode[8:6];
        em     = opcode[5:3];
        er     = opcode[2:0];
        src_ok = (em != EA_AREG) && ((em != EA_SPECIAL) || (er <= EA_LAST_SRC));
        mem_ok = (em > EA_AREG) && ((em != EA_SPECIAL) || (er <= EA_LAST_MEM));
        cls    = CLS_UNH;
        unique case (mode)
            MODE_LOAD: cls = CLS_LOAD;
            MODE_READ: cls = CLS_READ;
            MODE_EXEC: begin
                if (opcode[15:12] == LINE_C) begin
                    if (opm <= OPM_LONG_TO_DN) begin
                        cls = src_ok ? CLS_AND_DN : CLS_UNH;
                    end else if ((opm == OPM_MULU) || (opm == OPM_MULS)) begin
                        cls = src_ok ? CLS_MUL : CLS_UNH;
                    end else if ((opm == OPM_EXG_SAME) && (em == EA_DREG)) begin
                        cls = CLS_EXG_DD;
                    end else if ((opm == OPM_EXG_SAME) && (em == EA_AREG)) begin
                        cls = CLS_EXG_AA;
                    end else if ((opm == OPM_EXG_MIXED) && (em == EA_AREG)) begin
                        cls = CLS_EXG_DA;
                    end else if (mem_ok) begin
                        cls = CLS_AND_MEM;
                    end
                end
            end
            default: cls = CLS_UNH;
        endcase
        return cls;
    endfunction

endpackage

// ----- rtl/core/m68k_line_c_execute_unit.sv -----
// Top level of the line-C execute unit: register file memory, execute stage and result register.

// Execute unit for 68000 line-C instructions (AND to Dn, AND to memory, MULU, MULS, EXG),
// plus register load and read transactions. The sixteen registers D0-D7 and A0-A7 live in
// one synchronous memory with two read ports and one write port; the N Z V C flags live in
// a register. A transaction is accepted on s_valid and s_ready, its registers are read at
// that edge, and the execute stage computes the result (one 17 by 17 signed multiplier
// covers MULU and MULS), writes any register result and loads the result register once the
// result register is empty or m_ready is high; m_valid then rises. One transaction per
// cycle is sustained while m_ready stays high, for every form except EXG, which writes
// two registers through the single write port and so blocks the input: while an EXG sits
// in the execute stage s_ready is low, and its second write goes out in the following
// cycle. The newest register write is held aside and forwarded to a transaction whose
// memory read was issued on the same edge. Per-entry valid bits make every register read
// as zero after reset, so no clearing pass is needed. The result register lets a new
// transaction enter while a finished result waits on m_ready. AND to memory returns its
// sized value as write data with m_mem_write set; unknown modes and opcodes that are not
// executed forms return zero with m_unhandled set and change nothing.
`include "m68k_line_c_execute_unit_macros.svh"

module m68k_line_c_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_opcode,
    input  logic [31:0] s_operand,
    input  logic [3:0]  s_reg_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_mem_write,
    output logic [3:0]  m_flags_nzvc,
    output logic        m_unhandled
);

    // Register file: entries 0-7 are D0-D7, entries 8-15 are A0-A7.
    logic [31:0] regfile_mem [16];
    logic [15:0] rf_valid_reg;

    // Decode and read addresses of the incoming transaction.
    logic        s_fire;
    logic [3:0]  in_cls;
    logic [3:0]  in_addr_a;
    logic [3:0]  in_addr_b;

    // Execute stage.
    logic        s1_valid_reg;
    logic [3:0]  s1_cls_reg;
    logic [15:0] s1_opcode_reg;
    logic [31:0] s1_operand_reg;
    logic [3:0]  s1_addr_a_reg;
    logic [3:0]  s1_addr_b_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        s1_fire;
    logic        s1_is_exg;

    // Newest write, kept for forwarding.
    logic        lw_valid_reg;
    logic [3:0]  lw_addr_reg;
    logic [31:0] lw_data_reg;

    // Second write of an EXG.
    logic        pend_valid_reg;
    logic [3:0]  pend_addr_reg;
    logic [31:0] pend_data_reg;

    // Write port.
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic        s1_wr_en;

    // Execute datapath.
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] src;
    logic [1:0]  size;
    logic [31:0] mask;
    logic [31:0] and_val;
    logic [31:0] and_merged;
    logic        mul_signed;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_prod;
    logic [31:0] mul_val;
    logic [31:0] flag_val;
    logic [1:0]  flag_size;
    logic        flag_neg;
    logic        flags_update;
    logic [3:0]  cond_flags_reg;
    logic [3:0]  cond_flags_next;
    logic [31:0] result_next;
    logic        mem_write_next;
    logic        unhandled_next;

    // Result register.
    logic        m_valid_reg;
    logic [31:0] m_result_value_reg;
    logic        m_mem_write_reg;
    logic [3:0]  m_flags_nzvc_reg;
    logic        m_unhandled_reg;

    // ------------------------------------------------------------------
    // Input side: decode and choose the two register read addresses.
    // Port A names Dx (or Ax for EXG Ax,Ay) in execute mode and the
    // indexed register in load and read modes; port B names the ea register.
    // ------------------------------------------------------------------
    assign in_cls = m68k_lc_pkg::decode_op(s_mode, s_opcode);

    always_comb begin
        if (s_mode == m68k_lc_pkg::MODE_EXEC) begin
            in_addr_a = {in_cls == m68k_lc_pkg::CLS_EXG_AA, s_opcode[11:9]};
        end else begin
            in_addr_a = s_reg_index;
        end
        in_addr_b = {(in_cls == m68k_lc_pkg::CLS_EXG_AA) || (in_cls == m68k_lc_pkg::CLS_EXG_DA),
                     s_opcode[2:0]};
    end

    // An EXG in the execute stage blocks the next transaction, so its
    // second write never meets the write of a following transaction.
    assign s1_is_exg = (s1_cls_reg == m68k_lc_pkg::CLS_EXG_DD) ||
                       (s1_cls_reg == m68k_lc_pkg::CLS_EXG_AA) ||
                       (s1_cls_reg == m68k_lc_pkg::CLS_EXG_DA);
    assign s1_fire   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || (s1_fire && !s1_is_exg);
    assign s_fire    = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Register file memory: one write port, two registered read ports.
    // An entry never written since reset reads as zero.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            regfile_mem[wr_addr] <= wr_data;
        end
        if (s_fire) begin
            rd_a_reg <= rf_valid_reg[in_addr_a] ? regfile_mem[in_addr_a] : 32'd0;
            rd_b_reg <= rf_valid_reg[in_addr_b] ? regfile_mem[in_addr_b] : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (wr_en) begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // The newest write is always the current contents of its entry, so forwarding
    // from it is correct no matter how long the execute stage has been waiting.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr_en) begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Execute stage registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_cls_reg     <= in_cls;
            s1_opcode_reg  <= s_opcode;
            s1_operand_reg <= s_operand;
            s1_addr_a_reg  <= in_addr_a;
            s1_addr_b_reg  <= in_addr_b;
        end
    end

    assign op_a = (lw_valid_reg && (lw_addr_reg == s1_addr_a_reg)) ? lw_data_reg : rd_a_reg;
    assign op_b = (lw_valid_reg && (lw_addr_reg == s1_addr_b_reg)) ? lw_data_reg : rd_b_reg;

    // Source is Dy for a data-register ea, otherwise the fetched operand.
    assign src  = (s1_opcode_reg[5:3] == m68k_lc_pkg::EA_DREG) ? op_b : s1_operand_reg;
    // Opcode bits 7-6 (the low opmode bits) give the size for both AND directions.
    assign size = s1_opcode_reg[7:6];

    always_comb begin
        case (size)
            m68k_lc_pkg::SZ_BYTE: mask = 32'h0000_00FF;
            m68k_lc_pkg::SZ_WORD: mask = 32'h0000_FFFF;
            default:              mask = 32'hFFFF_FFFF;
        endcase
    end

    assign and_val    = op_a & ((s1_cls_reg == m68k_lc_pkg::CLS_AND_MEM) ? s1_operand_reg : src)
                        & mask;
    assign and_merged = (op_a & ~mask) | and_val;

    // MULS when the opmode's top bit is set; both forms go through one signed multiplier.
    assign mul_signed = s1_opcode_reg[8];
    assign mul_a      = $signed({mul_signed & op_a[15], op_a[15:0]});
    assign mul_b      = $signed({mul_signed & src[15], src[15:0]});
    assign mul_prod   = mul_a * mul_b;
    assign mul_val    = mul_prod[31:0];

    // Condition flags for AND and the multiplies: N and Z from the sized value, V and C clear.
    always_comb begin
        flags_update = 1'b0;
        flag_val     = and_val;
        flag_size    = size;
        case (s1_cls_reg)
            m68k_lc_pkg::CLS_AND_DN,
            m68k_lc_pkg::CLS_AND_MEM: begin
                flags_update = 1'b1;
            end
            m68k_lc_pkg::CLS_MUL: begin
                flags_update = 1'b1;
                flag_val     = mul_val;
                flag_size    = m68k_lc_pkg::SZ_LONG;
            end
            default: begin
                flags_update = 1'b0;
            end
        endcase
        case (flag_size)
            m68k_lc_pkg::SZ_BYTE: flag_neg = flag_val[7];
            m68k_lc_pkg::SZ_WORD: flag_neg = flag_val[15];
            default:              flag_neg = flag_val[31];
        endcase
        if (flags_update) begin
            cond_flags_next = {flag_neg, flag_val == 32'd0, 2'b00};
        end else begin
            cond_flags_next = cond_flags_reg;
        end
    end

    // Result, the first register write and its data. The first write always goes to
    // the port-A register; an EXG sends the port-A value to the port-B register next.
    always_comb begin
        result_next    = 32'd0;
        mem_write_next = 1'b0;
        unhandled_next = 1'b0;
        s1_wr_en       = 1'b0;
        case (s1_cls_reg)
            m68k_lc_pkg::CLS_AND_DN: begin
                result_next = and_merged;
                s1_wr_en    = 1'b1;
            end
            m68k_lc_pkg::CLS_MUL: begin
                result_next = mul_val;
                s1_wr_en    = 1'b1;
            end
            m68k_lc_pkg::CLS_AND_MEM: begin
                result_next    = and_val;
                mem_write_next = 1'b1;
            end
            m68k_lc_pkg::CLS_EXG_DD,
            m68k_lc_pkg::CLS_EXG_AA,
            m68k_lc_pkg::CLS_EXG_DA: begin
                result_next = op_b;
                s1_wr_en    = 1'b1;
            end
            m68k_lc_pkg::CLS_LOAD: begin
                result_next = s1_operand_reg;
                s1_wr_en    = 1'b1;
            end
            m68k_lc_pkg::CLS_READ: begin
                result_next = op_a;
            end
            default: begin
                unhandled_next = 1'b1;
            end
        endcase
    end

    // The pending EXG write and the execute stage never write in the same cycle.
    always_comb begin
        if (pend_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end else begin
            wr_en   = s1_fire && s1_wr_en;
            wr_addr = s1_addr_a_reg;
            wr_data = result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= s1_fire && s1_is_exg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            pend_addr_reg <= s1_addr_b_reg;
            pend_data_reg <= op_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_flags_reg <= 4'd0;
        end else if (s1_fire) begin
            cond_flags_reg <= cond_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_result_value_reg <= result_next;
            m_mem_write_reg    <= mem_write_next;
            m_flags_nzvc_reg   <= cond_flags_next;
            m_unhandled_reg    <= unhandled_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_mem_write    = m_mem_write_reg;
    assign m_flags_nzvc   = m_flags_nzvc_reg;
    assign m_unhandled    = m_unhandled_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `M68K_ASSERT_NOW(a_single_writer, aclk, aresetn, pend_valid_reg, !s1_valid_reg)
    `M68K_ASSERT_NOW(a_exg_blocks_input, aclk, aresetn, s1_valid_reg && s1_is_exg, !s_ready)
    `M68K_ASSERT_NEXT(a_exg_second_write, aclk, aresetn, s1_fire && s1_is_exg, pend_valid_reg && wr_en)

endmodule
